// ===== hdl/mmsa_pkg.sv =====
// Package with the types, constants and helpers of the masked mean and deviation accumulator.
package mmsa_pkg;
    localparam int NUM_CHANNELS = 32;
    localparam int CH_W = 5;
    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SAMPLE_W = 24;
    localparam int COUNT_W = 16;
    localparam int SUM_W = 40;
    localparam int SQ_W = 64;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACCUM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPORT = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] MISSING_RAW = -24'sd2559744;
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 24'sd8388607;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = -24'sd8388608;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CH_W-1:0] channel;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [COUNT_W-1:0] sample_count;
    } t_in_word;

    typedef struct packed {
        logic [CH_W-1:0] report_channel;
        logic signed [SAMPLE_W-1:0] mean_value;
        logic signed [SAMPLE_W-1:0] sdev_value;
    } t_out_word;

    // Start of a report job handed from the store stage to the arithmetic unit.
    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic [COUNT_W-1:0] count;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0] sq_sum;
    } t_job;
endpackage

// ===== hdl/mmsa_if.sv =====
// Valid and ready channel interface that carries one word of a given type.
interface mmsa_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/masked_mean_sdev_accumulator_core.sv =====
// Top level of the masked mean and sample deviation accumulator.
// Channel  | Dir | Word
// s_in     | in  | mode, channel, sample_value, sample_count
// m_out    | out | report_channel, mean_value, sdev_value
// Clear and accumulate words are read from the store in the accept cycle and written back
// in the cycle after, with forwarding between neighbor words to one channel.
// A report squares the sum, then divides it by a nonzero count for the mean; for counts of
// three or more it also divides the square, and unless the variance is negative, roots it.
// Reset is synchronous and active low; entries read as zero until first written.
// The input stalls while a report sits in stage one and an earlier report still waits.
module masked_mean_sdev_accumulator_core (
    input  logic i_clk,
    input  logic i_rst_n,
    mmsa_if.sink s_in,
    mmsa_if.source m_out
);
    import mmsa_pkg::*;

    logic job_valid, job_ready;
    t_job job;

    mmsa_store u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_in.valid), .i_word(s_in.data),
        .i_job_ready(job_ready), .o_ready(s_in.ready), .o_job_valid(job_valid),
        .o_job(job)
    );

    mmsa_arith u_arith (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(job_valid), .i_job(job),
        .o_job_ready(job_ready), .o_res_valid(m_out.valid), .o_res(m_out.data),
        .i_res_ready(m_out.ready)
    );
endmodule

// ===== hdl/mmsa_store.sv =====
// Channel store: sum and square-sum memories with read, modify and write back.
module mmsa_store (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  mmsa_pkg::t_in_word i_word,
    input  logic i_job_ready,
    output logic o_ready,
    output logic o_job_valid,
    output mmsa_pkg::t_job o_job
);
    import mmsa_pkg::*;

    logic [SUM_W-1:0] r_sum_mem [NUM_CHANNELS];
    logic [SQ_W-1:0] r_sq_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_vld;

    logic r_s1;
    t_in_word r_w1;
    logic r_v1;
    logic [SUM_W-1:0] r_rd_sum;
    logic [SQ_W-1:0] r_rd_sq;
    logic r_job_valid;
    t_job r_job;

    logic in_range, take, hold, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic signed [SUM_W-1:0] cur_sum, n_sum;
    logic [SQ_W-1:0] cur_sq, n_sq, sq_add;
    logic signed [SUM_W:0] sum_ext;
    logic [SQ_W:0] sq_ext;
    logic signed [2*SAMPLE_W-1:0] prod;

    assign in_range = {{(32-CH_W){1'b0}}, i_word.channel} < NUM_CHANNELS;
    assign hold = r_s1 && r_w1.mode == MODE_REPORT && r_job_valid && !i_job_ready;
    assign o_ready = !hold;
    assign take = i_valid && o_ready && in_range;
    assign rd_addr = i_word.channel[ADDR_W-1:0];
    assign wr_addr = r_w1.channel[ADDR_W-1:0];

    // A back-to-back access to the same entry takes the just-written value.
    always_comb begin
        cur_sum = r_v1 ? r_rd_sum : '0;
        cur_sq = r_v1 ? r_rd_sq : '0;
        prod = r_w1.sample_value * r_w1.sample_value;
        sq_add = {{(SQ_W-2*SAMPLE_W){1'b0}}, prod};
        sum_ext = {cur_sum[SUM_W-1], cur_sum}
            + {{(SUM_W+1-SAMPLE_W){r_w1.sample_value[SAMPLE_W-1]}}, r_w1.sample_value};
        sq_ext = {1'b0, cur_sq} + {1'b0, sq_add};
        if (sum_ext > $signed({SUM_MAX[SUM_W-1], SUM_MAX})) n_sum = SUM_MAX;
        else if (sum_ext < $signed({SUM_MIN[SUM_W-1], SUM_MIN})) n_sum = SUM_MIN;
        else n_sum = sum_ext[SUM_W-1:0];
        n_sq = sq_ext[SQ_W] ? {SQ_W{1'b1}} : sq_ext[SQ_W-1:0];
        wr_en = 1'b0;
        case (r_w1.mode)
            MODE_CLEAR: begin
                wr_en = r_s1;
                n_sum = '0;
                n_sq = '0;
            end
            MODE_ACCUM: wr_en = r_s1 && r_w1.sample_value != MISSING_RAW;
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_s1 <= 1'b0;
            r_job_valid <= 1'b0;
        end else begin
            r_job_valid <= (r_job_valid && !i_job_ready)
                || (!hold && r_s1 && r_w1.mode == MODE_REPORT);
            if (!hold) begin
                r_s1 <= take;
                if (take) begin
                    r_w1 <= i_word;
                    r_v1 <= r_vld[rd_addr] || (wr_en && wr_addr == rd_addr);
                    if (wr_en && wr_addr == rd_addr) begin
                        r_rd_sum <= n_sum;
                        r_rd_sq <= n_sq;
                    end else begin
                        r_rd_sum <= r_sum_mem[rd_addr];
                        r_rd_sq <= r_sq_mem[rd_addr];
                    end
                end
                if (r_s1 && r_w1.mode == MODE_REPORT) begin
                    r_job.channel <= r_w1.channel;
                    r_job.count <= r_w1.sample_count;
                    r_job.sum <= cur_sum;
                    r_job.sq_sum <= cur_sq;
                end
            end
            if (wr_en && !hold) begin
                r_vld[wr_addr] <= 1'b1;
                r_sum_mem[wr_addr] <= n_sum;
                r_sq_mem[wr_addr] <= n_sq;
            end
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job = r_job;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hold |=> $stable(r_w1)) else $error("stage one word changed while held");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job_valid && !i_job_ready) |=> r_job_valid && $stable(r_job))
        else $error("job dropped before it was taken");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && r_w1.mode == MODE_REPORT)) else $error("report item wrote the store");
endmodule

// ===== hdl/mmsa_arith.sv =====
// Report arithmetic: bit-serial divides and a square root.
module mmsa_arith (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  mmsa_pkg::t_job i_job,
    output logic o_job_ready,
    output logic o_res_valid,
    output mmsa_pkg::t_out_word o_res,
    input  logic i_res_ready
);
    import mmsa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQ_HI, ST_SQ_LO, ST_DIV, ST_VAR, ST_SQRT, ST_DONE
    } t_state;

    t_state r_state;
    logic [CH_W-1:0] r_ch;
    logic [COUNT_W-1:0] r_n;
    logic r_neg;
    logic [SUM_W-1:0] r_mag;
    logic [SQ_W-1:0] r_q;
    logic [127:0] r_num;
    logic [127:0] r_quo;
    logic [COUNT_W:0] r_rem;
    logic [6:0] r_cnt;
    logic [SUM_W-1:0] r_mq;
    logic [SQ_W-1:0] r_x, r_res, r_bit;
    logic [1:0] r_pass;
    logic r_res_valid;
    t_out_word r_out;

    logic [COUNT_W+1:0] rem_sh;
    logic [COUNT_W:0] dvs;
    logic [COUNT_W:0] rem_nx;
    logic q_bit;
    logic [SUM_W+19:0] part;
    logic [SQ_W:0] trial;
    logic signed [SUM_W:0] mean_s;
    logic signed [SAMPLE_W-1:0] mean_c, sdev_v;

    assign dvs = (r_pass == 2'd2) ? {1'b0, r_n - 1'b1} : {1'b0, r_n};
    assign rem_sh = {r_rem, (r_pass == 2'd0) ? r_quo[SUM_W-1] : r_num[127]};
    assign q_bit = rem_sh >= {1'b0, dvs};
    assign rem_nx = q_bit ? (COUNT_W+1)'(rem_sh - {1'b0, dvs}) : rem_sh[COUNT_W:0];
    assign part = ((r_state == ST_SQ_HI) ? r_mag[SUM_W-1:20] : r_mag[19:0]) * r_mag;
    assign trial = {1'b0, r_res} + {1'b0, r_bit};
    assign mean_s = r_neg ? -$signed({1'b0, r_mq}) : $signed({1'b0, r_mq});
    always_comb begin
        if (mean_s > $signed({{(SUM_W-SAMPLE_W+1){1'b0}}, OUT_MAX})) mean_c = OUT_MAX;
        else if (mean_s < $signed({{(SUM_W-SAMPLE_W+1){1'b1}}, OUT_MIN})) mean_c = OUT_MIN;
        else mean_c = mean_s[SAMPLE_W-1:0];
        sdev_v = (r_res > {{(SQ_W-SAMPLE_W){1'b0}}, OUT_MAX}) ? OUT_MAX
            : r_res[SAMPLE_W-1:0];
    end

    assign o_job_ready = r_state == ST_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && i_res_ready && r_state != ST_DONE) r_res_valid <= 1'b0;
            case (r_state)
                ST_IDLE: if (i_job_valid) begin
                    r_ch <= i_job.channel;
                    r_n <= i_job.count;
                    r_neg <= i_job.sum[SUM_W-1];
                    r_mag <= i_job.sum[SUM_W-1] ? SUM_W'(-i_job.sum) : i_job.sum;
                    r_q <= i_job.sq_sum;
                    r_num <= '0;
                    r_state <= ST_SQ_HI;
                end
                ST_SQ_HI: begin
                    // Square built from two 20-bit halves: high half times magnitude.
                    r_num <= {{(128-SUM_W-20){1'b0}}, part} << 20;
                    r_state <= ST_SQ_LO;
                end
                ST_SQ_LO: begin
                    r_num <= r_num + {{(128-SUM_W-20){1'b0}}, part};
                    r_pass <= 2'd0;
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_state <= (r_n == '0) ? ST_DONE : ST_DIV;
                    r_mq <= '0;
                    r_quo <= {{(128-SUM_W){1'b0}}, r_mag};
                end
                ST_DIV: begin
                    // Pass 0 divides the magnitude, pass 1 the square, pass 2 the variance.
                    if (r_pass == 2'd0) begin
                        r_mq <= {r_mq[SUM_W-2:0], q_bit};
                        if (r_cnt == 7'(SUM_W-1)) begin
                            r_cnt <= '0;
                            r_rem <= '0;
                            r_pass <= 2'd1;
                            r_quo <= '0;
                            if (r_n < 16'd3) r_state <= ST_DONE;
                        end else begin
                            r_rem <= rem_nx;
                            r_quo <= {r_quo[126:0], 1'b0};
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end else begin
                        r_rem <= rem_nx;
                        r_quo <= {r_quo[126:0], q_bit};
                        r_num <= {r_num[126:0], 1'b0};
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == 7'd127) r_state <= ST_VAR;
                    end
                end
                ST_VAR: if (r_pass == 2'd1) begin
                    r_rem <= '0;
                    if (r_quo[127:64] != '0 || r_quo[63:0] > r_q) begin
                        r_res <= '0;
                        r_cnt <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_num <= {r_q - r_quo[63:0], 64'd0};
                        r_quo <= '0;
                        r_pass <= 2'd2;
                        r_state <= ST_DIV;
                        r_cnt <= 7'd64;
                    end
                end else begin
                    r_x <= r_quo[63:0];
                    r_res <= '0;
                    r_bit <= {2'b01, {(SQ_W-2){1'b0}}};
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (r_x >= trial[SQ_W-1:0] && !trial[SQ_W]) begin
                        r_x <= r_x - trial[SQ_W-1:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) r_state <= ST_DONE;
                end
                ST_DONE: if (!r_res_valid || i_res_ready) begin
                    r_res_valid <= 1'b1;
                    r_out.report_channel <= r_ch;
                    r_out.mean_value <= (r_n == '0) ? MISSING_RAW : mean_c;
                    r_out.sdev_value <= (r_n < 16'd3) ? MISSING_RAW : sdev_v;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !i_res_ready) |=> r_res_valid && $stable(r_out))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT) |-> $onehot(r_bit)) else $error("root bit not one-hot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_pass != 2'd0) |-> r_n > 16'd2)
        else $error("deviation divide with small count");
endmodule
